// File: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the sorter RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define KSS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define KSS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/kss_pkg.sv
// ---------------------------------------------------------------------------
// kss_pkg
// Constants, types and helper functions of the k-sorted stream sorter.
// ---------------------------------------------------------------------------
package kss_pkg;

  localparam int DATA_BITS  = 32;
  localparam int MAX_WINDOW = 31;
  localparam int HEAP_DEPTH = MAX_WINDOW + 1;
  localparam int IDX_W      = $clog2(HEAP_DEPTH);
  localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
  localparam int K_W        = 5;
  localparam int CMP_W      = K_W + CNT_W;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic push_start;
    logic su_step;
    logic pop_start;
    logic pop_load;
    logic sd_step;
    logic emit;
  } kss_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic full;
    logic su_done;
    logic sd_done;
    logic pop_req;
    logic drain_more;
    logic out_free;
  } kss_sts_t;

  // Signed order of two heap words
  function automatic logic heap_less(input logic [DATA_BITS-1:0] a,
                                     input logic [DATA_BITS-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

  // Parent slot of a heap slot (slot zero has none)
  function automatic logic [IDX_W-1:0] heap_parent(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] im1;
    im1 = i - 1'b1;
    return im1 >> 1;
  endfunction

endpackage

// File: hw/rtl/kss_if.sv
// ---------------------------------------------------------------------------
// kss channel interfaces
// Valid/ready channels for the input items and the sorted results.
// ---------------------------------------------------------------------------
interface kss_in_if import kss_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [DATA_BITS-1:0] value;
  logic                        last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink   (input valid, input value, input last_item, output ready);
endinterface

interface kss_out_if import kss_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [DATA_BITS-1:0] sorted_value;
  logic                        end_of_run;

  modport source (output valid, output sorted_value, output end_of_run, input ready);
  modport sink   (input valid, input sorted_value, input end_of_run, output ready);
endinterface

// File: hw/rtl/kss_datapath.sv
// ---------------------------------------------------------------------------
// kss_datapath
// Heap memory, sift-up/sift-down compare unit, counters and result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module kss_datapath import kss_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [K_W-1:0]              cfg_wdata,
  input  logic signed [DATA_BITS-1:0] in_value,
  input  logic                        in_last,
  input  kss_cmd_t                    cmd,
  output kss_sts_t                    sts,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [DATA_BITS-1:0] out_value,
  output logic                        out_end
);

  // Heap storage, one write and two registered read ports
  logic [DATA_BITS-1:0] heap_mem [HEAP_DEPTH];
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [DATA_BITS-1:0] mem_wdata;
  logic [IDX_W-1:0]     rd_a_addr;
  logic [IDX_W-1:0]     rd_b_addr;
  logic [DATA_BITS-1:0] rd_a_r;
  logic [DATA_BITS-1:0] rd_b_r;

  // Control registers
  logic [K_W-1:0]   k_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             last_r, last_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Payload registers
  logic [DATA_BITS-1:0] val_r, val_nxt;
  logic [DATA_BITS-1:0] top_r, top_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [DATA_BITS-1:0] out_value_r, out_value_nxt;
  logic                 out_end_r, out_end_nxt;

  // Sift-down child selection
  logic [IDX_W+1:0]     c1, c2, cnt_x;
  logic                 has_c1, has_c2, sel_b;
  logic [DATA_BITS-1:0] c_val;
  logic [IDX_W-1:0]     c_idx;
  logic [IDX_W-1:0]     par_i;
  logic [CMP_W-1:0]     k_eff;
  logic                 su_done, sd_done;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      heap_mem[mem_waddr] <= mem_wdata;
    end
    rd_a_r <= heap_mem[rd_a_addr];
    rd_b_r <= heap_mem[rd_b_addr];
  end

  // Pick the smaller existing child of the current slot
  always_comb begin
    c1     = {1'b0, idx_r, 1'b1};
    c2     = c1 + 1'b1;
    cnt_x  = (IDX_W+2)'(count_r);
    has_c1 = c1 < cnt_x;
    has_c2 = c2 < cnt_x;
    sel_b  = has_c2 && heap_less(rd_b_r, rd_a_r);
    c_val  = sel_b ? rd_b_r : rd_a_r;
    c_idx  = sel_b ? c2[IDX_W-1:0] : c1[IDX_W-1:0];
    par_i  = heap_parent(idx_r);
  end

  assign su_done = (idx_r == '0) || !heap_less(val_r, rd_a_r);
  assign sd_done = !has_c1 || !heap_less(c_val, val_r);

  // Effective window, saturated to the heap limit
  assign k_eff = (CMP_W'(k_r) > CMP_W'(MAX_WINDOW)) ? CMP_W'(MAX_WINDOW) : CMP_W'(k_r);

  // Report status
  always_comb begin
    sts.full       = count_r == CNT_W'(HEAP_DEPTH);
    sts.su_done    = su_done;
    sts.sd_done    = sd_done;
    sts.pop_req    = (CMP_W'(count_r) > k_eff) || (last_r && (count_r != '0));
    sts.drain_more = last_r && (count_r != '0);
    sts.out_free   = !out_valid_r || out_ready;
  end

  // Execute commands
  always_comb begin
    mem_we        = 1'b0;
    mem_waddr     = idx_r;
    mem_wdata     = val_r;
    rd_a_addr     = '0;
    rd_b_addr     = '0;
    count_nxt     = count_r;
    last_nxt      = last_r;
    val_nxt       = val_r;
    top_nxt       = top_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_end_nxt   = out_end_r;

    if (cmd.load) begin
      val_nxt  = in_value;
      last_nxt = in_last;
    end

    // Open a new leaf and fetch its parent
    if (cmd.push_start) begin
      idx_nxt   = count_r[IDX_W-1:0];
      count_nxt = count_r + 1'b1;
      rd_a_addr = heap_parent(count_r[IDX_W-1:0]);
    end

    // Move the parent down or settle the new value
    if (cmd.su_step) begin
      mem_we = 1'b1;
      if (su_done) begin
        mem_wdata = val_r;
      end else begin
        mem_wdata = rd_a_r;
        idx_nxt   = par_i;
        rd_a_addr = heap_parent(par_i);
      end
    end

    // Fetch root and last entry, shrink the heap
    if (cmd.pop_start) begin
      rd_a_addr = '0;
      rd_b_addr = IDX_W'(count_r - 1'b1);
      count_nxt = count_r - 1'b1;
    end

    // Hold the root as the result, sift the last entry from the root
    if (cmd.pop_load) begin
      top_nxt   = rd_a_r;
      val_nxt   = rd_b_r;
      idx_nxt   = '0;
      rd_a_addr = IDX_W'(1);
      rd_b_addr = IDX_W'(2);
    end

    // Move the smaller child up or settle the moving value
    if (cmd.sd_step) begin
      if (sd_done) begin
        mem_we    = count_r != '0;
        mem_wdata = val_r;
      end else begin
        mem_we    = 1'b1;
        mem_wdata = c_val;
        idx_nxt   = c_idx;
        rd_a_addr = IDX_W'({c_idx, 1'b1});
        rd_b_addr = IDX_W'({c_idx, 1'b1} + 1'b1);
      end
    end

    // Result register
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = top_r;
      out_end_nxt   = last_r && (count_r == '0);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      count_r     <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        k_r <= cfg_wdata;
      end
      count_r     <= count_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r       <= val_nxt;
    top_r       <= top_nxt;
    idx_r       <= idx_nxt;
    out_value_r <= out_value_nxt;
    out_end_r   <= out_end_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_value = $signed(out_value_r);
  assign out_end   = out_end_r;

  `KSS_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(HEAP_DEPTH))
  `KSS_ASSERT_IMP(a_emit_free, clk, rst_n, cmd.emit, !out_valid_r || out_ready)
  `KSS_ASSERT_NXT(a_pop_shrinks, clk, rst_n, cmd.pop_start, count_r == $past(count_r) - 1'b1)

endmodule

// File: hw/rtl/kss_controller.sv
// ---------------------------------------------------------------------------
// kss_controller
// Sequencer for push, sift-up, pop, sift-down and result hand-off.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module kss_controller import kss_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  kss_sts_t sts,
  output kss_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PUSH  = 3'd1;
  localparam logic [2:0] S_SU    = 3'd2;
  localparam logic [2:0] S_POPRD = 3'd3;
  localparam logic [2:0] S_POPLD = 3'd4;
  localparam logic [2:0] S_SD    = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0] state_r, state_nxt;

  assign in_ready = state_r == S_IDLE;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (sts.full) begin
          state_nxt = sts.pop_req ? S_POPRD : S_IDLE;
        end else begin
          cmd.push_start = 1'b1;
          state_nxt      = S_SU;
        end
      end
      S_SU: begin
        cmd.su_step = 1'b1;
        if (sts.su_done) begin
          state_nxt = sts.pop_req ? S_POPRD : S_IDLE;
        end
      end
      S_POPRD: begin
        cmd.pop_start = 1'b1;
        state_nxt     = S_POPLD;
      end
      S_POPLD: begin
        cmd.pop_load = 1'b1;
        state_nxt    = S_SD;
      end
      S_SD: begin
        cmd.sd_step = 1'b1;
        if (sts.sd_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.drain_more ? S_POPRD : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `KSS_ASSERT_NXT(a_accept_push, clk, rst_n, in_valid && in_ready, state_r == S_PUSH)
  `KSS_ASSERT_IMP(a_cmd_onehot, clk, rst_n, 1'b1, $onehot0(cmd))
  `KSS_ASSERT_NXT(a_emit_hold, clk, rst_n, (state_r == S_EMIT) && !sts.out_free, state_r == S_EMIT)

endmodule

// File: hw/rtl/k_sorted_stream_sorter_unit.sv
// ---------------------------------------------------------------------------
// k_sorted_stream_sorter_unit
// Sorts a nearly sorted stream through a sliding-window min-heap.
// ---------------------------------------------------------------------------
// Channel | Dir | Handshake   | Payload
// in_ch   | in  | valid/ready | value (32b signed), last_item
// out_ch  | out | valid/ready | sorted_value (32b signed), end_of_run
// cfg     | in  | write only  | cfg_wdata = window_k (5b)
//
// One item at a time: the push loads, opens a leaf and sifts up U moves (0..5).
// Each result adds a pop read, a pop load, D sift-down moves (0..4) and the
// emit; the heap memory gives one compare step per cycle on its two read ports.
// A result register holds the last result, so a new item is taken while it waits.
// A stalled result register holds the sequencer before the next result.
// rst_n is synchronous: it empties the heap and clears window_k; no clearing pass.
// ---------------------------------------------------------------------------
module k_sorted_stream_sorter_unit import kss_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [K_W-1:0] cfg_wdata,
  kss_in_if.sink         in_ch,
  kss_out_if.source      out_ch
);

  kss_cmd_t cmd;
  kss_sts_t sts;

  kss_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  kss_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_value  (in_ch.value),
    .in_last   (in_ch.last_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_value (out_ch.sorted_value),
    .out_end   (out_ch.end_of_run)
  );

endmodule
